@@ sv/minv_pkg.sv @@
// Shared constants and a width helper for the 3x3 matrix inverse block.
// No dependencies; every other file in this folder uses it.
`timescale 1ns / 1ps
package minv_pkg;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Larger of two elaboration-time widths.
   function automatic int minv_max(input int a, input int b);
      return (a > b) ? a : b;
   endfunction
endpackage

@@ sv/matrix_3x3_inverse.sv @@
// 3x3 fixed-point matrix inverse, pipelined from input transfer to a registered result.
// Throughput one matrix per cycle unless stalled; quotient stages after the first retire one bit each.
// The whole pipeline stalls together while a result waits on the output register.
// Reset (synchronous, active high) clears the stage valid bits and the output valid.
// Depends on minv_pkg, minv_adj, minv_det and minv_div.
`timescale 1ns / 1ps
module matrix_3x3_inverse #(
   parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = minv_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ELEM_WIDTH-1:0] req_col0_row0,
   input  logic signed [ELEM_WIDTH-1:0] req_col1_row0,
   input  logic signed [ELEM_WIDTH-1:0] req_col2_row0,
   input  logic signed [ELEM_WIDTH-1:0] req_col0_row1,
   input  logic signed [ELEM_WIDTH-1:0] req_col1_row1,
   input  logic signed [ELEM_WIDTH-1:0] req_col2_row1,
   input  logic signed [ELEM_WIDTH-1:0] req_col0_row2,
   input  logic signed [ELEM_WIDTH-1:0] req_col1_row2,
   input  logic signed [ELEM_WIDTH-1:0] req_col2_row2,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c0_r0,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c1_r0,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c2_r0,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c0_r1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c1_r1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c2_r1,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c0_r2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c1_r2,
   output logic signed [ELEM_WIDTH-1:0] rsp_inv_c2_r2,
   output logic                         rsp_singular
);
   import minv_pkg::*;

   localparam int W    = ELEM_WIDTH;
   localparam int DETW = 3 * W + 3;
   // Register stages up to the last quotient bit: two for the adjugate,
   // two for the determinant, one for magnitudes, W + 1 for the quotient.
   localparam int LAT  = W + 6;
   // Line index at which the determinant's zero test is registered and the singular bit
   // joins the pass-through line.
   localparam int SING_IDX = 4;

   // The pipeline moves as a whole whenever the output register can take
   // a transfer; bubbles travel with valid bits cleared.
   logic en;
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   logic signed [W-1:0] req_elem [0:8];
   assign req_elem[0] = req_col0_row0;
   assign req_elem[1] = req_col1_row0;
   assign req_elem[2] = req_col2_row0;
   assign req_elem[3] = req_col0_row1;
   assign req_elem[4] = req_col1_row1;
   assign req_elem[5] = req_col2_row1;
   assign req_elem[6] = req_col0_row2;
   assign req_elem[7] = req_col1_row2;
   assign req_elem[8] = req_col2_row2;

   // Pass-through line: the input matrix and, from the determinant stage
   // on, the singular flag travel alongside the arithmetic.
   logic                vld_ff  [0:LAT-1];
   logic signed [W-1:0] mat_ff  [0:LAT-1][0:8];
   logic                sing_ff [0:LAT-1];

   logic signed [2*W:0]   adj_w     [0:8];
   logic signed [2*W:0]   adj_d1_ff [0:8];
   logic signed [2*W:0]   adj_d2_ff [0:8];
   logic signed [DETW-1:0] det_w;
   logic signed [W-1:0]   quo_w     [0:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LAT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < LAT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mat_ff[0]  <= req_elem;
         sing_ff[0] <= 1'b0;
         for (int s = 1; s < LAT; s++) begin
            mat_ff[s] <= mat_ff[s-1];
            if (s == SING_IDX) begin
               sing_ff[s] <= (det_w == '0);
            end else begin
               sing_ff[s] <= sing_ff[s-1];
            end
         end
         adj_d1_ff <= adj_w;
         adj_d2_ff <= adj_d1_ff;
      end
   end

   // Nine adjugate lanes. Entry (r, c) is the cofactor of the transposed
   // position, using the wrapped neighbors of row c and column r.
   for (genvar r = 0; r < 3; r++) begin : g_row
      for (genvar c = 0; c < 3; c++) begin : g_col
         localparam int C1 = (c + 1) % 3;
         localparam int C2 = (c + 2) % 3;
         localparam int R1 = (r + 1) % 3;
         localparam int R2 = (r + 2) % 3;

         minv_adj #(
            .ELEM_WIDTH(W)
         ) u_adj (
            .clock(clock),
            .en   (en),
            .a    (req_elem[C1*3+R1]),
            .b    (req_elem[C2*3+R2]),
            .c    (req_elem[C1*3+R2]),
            .d    (req_elem[C2*3+R1]),
            .adj  (adj_w[r*3+c])
         );

         minv_div #(
            .ELEM_WIDTH(W),
            .FRAC_BITS (FRAC_BITS)
         ) u_div (
            .clock(clock),
            .en   (en),
            .adj  (adj_d2_ff[r*3+c]),
            .det  (det_w),
            .quo  (quo_w[r*3+c])
         );
      end
   end

   // Merging stage: the determinant is row 0 against the first adjugate
   // column, with the row taken from the line where the adjugate appears.
   minv_det #(
      .ELEM_WIDTH(W)
   ) u_det (
      .clock(clock),
      .en   (en),
      .a0   (mat_ff[1][0]),
      .a1   (mat_ff[1][1]),
      .a2   (mat_ff[1][2]),
      .j0   (adj_w[0]),
      .j1   (adj_w[3]),
      .j2   (adj_w[6]),
      .det  (det_w)
   );

   // Output register. A singular matrix returns its own elements.
   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_elem_ff [0:8];
   logic                rsp_sing_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_sing_ff <= sing_ff[LAT-1];
         for (int i = 0; i < 9; i++) begin
            rsp_elem_ff[i] <= sing_ff[LAT-1] ? mat_ff[LAT-1][i] : quo_w[i];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_inv_c0_r0 = rsp_elem_ff[0];
   assign rsp_inv_c1_r0 = rsp_elem_ff[1];
   assign rsp_inv_c2_r0 = rsp_elem_ff[2];
   assign rsp_inv_c0_r1 = rsp_elem_ff[3];
   assign rsp_inv_c1_r1 = rsp_elem_ff[4];
   assign rsp_inv_c2_r1 = rsp_elem_ff[5];
   assign rsp_inv_c0_r2 = rsp_elem_ff[6];
   assign rsp_inv_c1_r2 = rsp_elem_ff[7];
   assign rsp_inv_c2_r2 = rsp_elem_ff[8];

   // An accepted transfer occupies the first stage on the next cycle.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transfer did not enter the pipeline");

   // When the pipeline moves, the singular flag registers whether the previous cycle's determinant was zero.
   a_sing_tracks_det: assert property (@(posedge clock) disable iff (reset)
      en |=> (sing_ff[SING_IDX] == $past(det_w == '0)))
      else $error("singular flag does not follow the determinant");

   // A held result is never replaced while the pipeline is stalled.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff[LAT-1]) && $stable(rsp_sing_ff))
      else $error("pipeline moved during a stall");
endmodule

@@ sv/minv_adj.sv @@
// One adjugate lane: a*b - c*d, exact, two pipeline registers deep.
// Depends on minv_pkg for parameter defaults.
`timescale 1ns / 1ps
module minv_adj #(
   parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [ELEM_WIDTH-1:0] a,
   input  logic signed [ELEM_WIDTH-1:0] b,
   input  logic signed [ELEM_WIDTH-1:0] c,
   input  logic signed [ELEM_WIDTH-1:0] d,
   output logic signed [2*ELEM_WIDTH:0] adj
);
   import minv_pkg::*;

   localparam int PW = 2 * ELEM_WIDTH;

   logic signed [PW-1:0] p_in, s_in, p_ff, s_ff;
   logic signed [PW:0]   adj_in, adj_ff;

   assign p_in   = a * b;
   assign s_in   = c * d;
   assign adj_in = (PW+1)'(p_ff) - (PW+1)'(s_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= p_in;
         s_ff   <= s_in;
         adj_ff <= adj_in;
      end
   end

   assign adj = adj_ff;
endmodule

@@ sv/minv_det.sv @@
// Merging stage: determinant from row 0 and the first adjugate column.
// Depends on minv_pkg for parameter defaults. Two pipeline registers deep.
`timescale 1ns / 1ps
module minv_det #(
   parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [ELEM_WIDTH-1:0]   a0,
   input  logic signed [ELEM_WIDTH-1:0]   a1,
   input  logic signed [ELEM_WIDTH-1:0]   a2,
   input  logic signed [2*ELEM_WIDTH:0]   j0,
   input  logic signed [2*ELEM_WIDTH:0]   j1,
   input  logic signed [2*ELEM_WIDTH:0]   j2,
   output logic signed [3*ELEM_WIDTH+2:0] det
);
   import minv_pkg::*;

   localparam int W    = ELEM_WIDTH;
   localparam int DETW = 3 * W + 3;

   logic signed [W-1:0]  a_s [0:2];
   logic signed [2*W:0]  j_s [0:2];
   logic signed [2*W:0]  plo_ff [0:2];
   logic signed [2*W:0]  phi_ff [0:2];
   logic signed [DETW-1:0] det_in, det_ff;

   assign a_s[0] = a0;
   assign a_s[1] = a1;
   assign a_s[2] = a2;
   assign j_s[0] = j0;
   assign j_s[1] = j1;
   assign j_s[2] = j2;

   // The wide adjugate entry is split into an unsigned low half and a signed
   // high half so the operands of each product stay near the element width.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            plo_ff[i] <= a_s[i] * $signed({1'b0, j_s[i][W-1:0]});
            phi_ff[i] <= a_s[i] * $signed(j_s[i][2*W:W]);
         end
         det_ff <= det_in;
      end
   end

   always_comb begin
      det_in = '0;
      for (int i = 0; i < 3; i++) begin
         det_in = det_in + DETW'(plo_ff[i]) + (DETW'(phi_ff[i]) <<< W);
      end
   end

   assign det = det_ff;
endmodule

@@ sv/minv_div.sv @@
// One divider lane: |adj| << 2F over |det|, an overflow stage, one quotient bit per later stage,
// then sign and saturation. Depends on minv_pkg for defaults and widths.
`timescale 1ns / 1ps
module minv_div #(
   parameter int ELEM_WIDTH = minv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = minv_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [2*ELEM_WIDTH:0]   adj,
   input  logic signed [3*ELEM_WIDTH+2:0] det,
   output logic signed [ELEM_WIDTH-1:0]   quo
);
   import minv_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int AW = 2 * W + 1;
   localparam int NW = AW + 2 * FRAC_BITS;
   localparam int DW = 3 * W + 3;
   localparam int QB = W;
   localparam int CW = minv_max(DW + QB, NW);

   logic [NW-1:0] n_ff;
   logic [DW-1:0] dp_ff;
   logic          negp_ff;

   logic [NW-1:0] rem_ff [0:QB];
   logic [W-1:0]  q_ff   [0:QB];
   logic          ovf_ff [0:QB];
   logic [DW-1:0] d_ff   [0:QB];
   logic          neg_ff [0:QB];

   logic [AW-1:0] amag;
   logic [DW-1:0] dmag;

   assign amag = adj[AW-1] ? AW'(-adj) : AW'(adj);
   assign dmag = det[DW-1] ? DW'(-det) : DW'(det);

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff    <= NW'(amag) << (2 * FRAC_BITS);
         dp_ff   <= dmag;
         negp_ff <= adj[AW-1] ^ det[DW-1];
      end
   end

   // The first stage only flags a quotient of 2^QB or more; the others
   // each settle one quotient bit, most significant first.
   for (genvar i = 0; i <= QB; i++) begin : g_stage
      localparam int K = QB - i;
      logic [NW-1:0] rem_src;
      logic [W-1:0]  q_src;
      logic          ovf_src;
      logic [DW-1:0] d_src;
      logic          neg_src;
      logic [CW-1:0] sh_d;
      logic          ge;

      if (i == 0) begin : g_first
         assign rem_src = n_ff;
         assign q_src   = '0;
         assign ovf_src = 1'b0;
         assign d_src   = dp_ff;
         assign neg_src = negp_ff;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign q_src   = q_ff[i-1];
         assign ovf_src = ovf_ff[i-1];
         assign d_src   = d_ff[i-1];
         assign neg_src = neg_ff[i-1];
      end

      assign sh_d = CW'(d_src) << K;
      assign ge   = CW'(rem_src) >= sh_d;

      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[i]   <= d_src;
            neg_ff[i] <= neg_src;
            if (i == 0) begin
               ovf_ff[i] <= ge;
               rem_ff[i] <= rem_src;
               q_ff[i]   <= q_src;
            end else begin
               ovf_ff[i] <= ovf_src;
               if (ge) begin
                  rem_ff[i] <= rem_src - NW'(sh_d);
                  q_ff[i]   <= q_src | (W'(1) << K);
               end else begin
                  rem_ff[i] <= rem_src;
                  q_ff[i]   <= q_src;
               end
            end
         end
      end
   end

   localparam logic [W-1:0] LIM = W'(1) << (W - 1);

   logic [W-1:0] mag;
   assign mag = q_ff[QB];

   always_comb begin
      if (neg_ff[QB]) begin
         quo = (ovf_ff[QB] || (mag > LIM)) ? $signed(LIM) : $signed(-mag);
      end else begin
         quo = (ovf_ff[QB] || mag[W-1]) ? $signed(LIM - W'(1)) : $signed(mag);
      end
   end
endmodule

@@ bench/minv_checker.sv @@
// Checker for the 3x3 matrix inverse: watches both channels, predicts each inverse
// and compares every result field. Depends on minv_pkg for the element width.
`timescale 1ns / 1ps
module minv_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic [9*minv_pkg::ELEM_WIDTH_DEF-1:0]   req_flat,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic [9*minv_pkg::ELEM_WIDTH_DEF-1:0]   rsp_flat,
   input  logic                                    rsp_singular,
   output int                                      fail_count,
   output int                                      pending_count,
   output int                                      checked_count,
   output int                                      singular_count
);
   import minv_pkg::*;

   localparam int W = ELEM_WIDTH_DEF;
   localparam int F = FRAC_BITS_DEF;
   typedef logic signed [255:0] wide_type;
   typedef struct {
      logic [9*W-1:0] elems;
      logic           singular;
   } inverse_type;

   localparam wide_type ELEM_MAX = (wide_type'(1) <<< (W - 1)) - 1;
   localparam wide_type ELEM_MIN = -(wide_type'(1) <<< (W - 1));

   inverse_type expected_inverses[$];

   // Adjugate over the determinant, truncated toward zero and saturated; a singular matrix returns itself.
   function automatic inverse_type invert_matrix(input logic [9*W-1:0] m);
      wide_type    a[3][3];
      wide_type    adj[3][3];
      wide_type    det;
      wide_type    q;
      inverse_type res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            a[r][c] = $signed(m[(r * 3 + c) * W +: W]);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            adj[r][c] = a[(c + 1) % 3][(r + 1) % 3] * a[(c + 2) % 3][(r + 2) % 3]
                      - a[(c + 1) % 3][(r + 2) % 3] * a[(c + 2) % 3][(r + 1) % 3];
      det = 0;
      for (int c = 0; c < 3; c++)
         det = det + a[0][c] * adj[c][0];
      if (det == 0) begin
         res.elems    = m;
         res.singular = 1'b1;
         return res;
      end
      for (int i = 0; i < 9; i++) begin
         q = (adj[i / 3][i % 3] <<< (2 * F)) / det;
         if (q > ELEM_MAX) q = ELEM_MAX;
         else if (q < ELEM_MIN) q = ELEM_MIN;
         res.elems[i * W +: W] = q[W-1:0];
      end
      res.singular = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [W-1:0] want,
                                  input logic [W-1:0] got);
      $display("MISMATCH result %0d field %s: expected %h, got %h",
               checked_count, field, want, got);
      fail_count++;
   endtask

   initial begin
      fail_count     = 0;
      pending_count  = 0;
      checked_count  = 0;
      singular_count = 0;
   end

   // Outputs are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      inverse_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_inverses.push_back(invert_matrix(req_flat));
         if (rsp_valid && rsp_ready) begin
            if (expected_inverses.size() == 0) begin
               // A result arrived with nothing outstanding.
               report_mismatch("rsp_valid", W'(0), W'(1));
            end else begin
               want = expected_inverses.pop_front();
               for (int i = 0; i < 9; i++)
                  if (rsp_flat[i * W +: W] !== want.elems[i * W +: W])
                     report_mismatch($sformatf("inv_c%0d_r%0d", i % 3, i / 3),
                                     want.elems[i * W +: W], rsp_flat[i * W +: W]);
               if (rsp_singular !== want.singular)
                  report_mismatch("singular", W'(want.singular), W'(rsp_singular));
               if (want.singular) singular_count++;
            end
            checked_count++;
         end
         pending_count = expected_inverses.size();
      end
   end
endmodule

@@ bench/tb_matrix_3x3_inverse.sv @@
// Top of the 3x3 matrix inverse testbench: clock, reset, stimulus and verdict.
// Depends on minv_pkg, minv_checker and the matrix_3x3_inverse block.
`timescale 1ns / 1ps
module tb_matrix_3x3_inverse;
   import minv_pkg::*;

   localparam int W          = ELEM_WIDTH_DEF;
   localparam int F          = FRAC_BITS_DEF;
   localparam int RANDOM_CNT = 840;
   localparam int HOLD_LEN   = 300;
   localparam int CYCLE_CAP  = 400000;
   localparam logic [W-1:0] ONE  = W'(1) << F;
   localparam logic [W-1:0] EMAX = {1'b0, {(W - 1){1'b1}}};
   localparam logic [W-1:0] EMIN = {1'b1, {(W - 1){1'b0}}};

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   logic [9*W-1:0] req_flat = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [9*W-1:0] rsp_flat;
   logic           rsp_singular;

   int  fail_count, pending_count, checked_count, singular_count;
   int  sent_count = 0;
   int  cycle_count = 0;
   bit  no_gaps = 1'b0;
   int  holds_asked = 0;
   int  holds_served = 0;
   int  hold_left = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   matrix_3x3_inverse u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_col0_row0 (req_flat[0*W +: W]),
      .req_col1_row0 (req_flat[1*W +: W]),
      .req_col2_row0 (req_flat[2*W +: W]),
      .req_col0_row1 (req_flat[3*W +: W]),
      .req_col1_row1 (req_flat[4*W +: W]),
      .req_col2_row1 (req_flat[5*W +: W]),
      .req_col0_row2 (req_flat[6*W +: W]),
      .req_col1_row2 (req_flat[7*W +: W]),
      .req_col2_row2 (req_flat[8*W +: W]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_inv_c0_r0 (rsp_flat[0*W +: W]),
      .rsp_inv_c1_r0 (rsp_flat[1*W +: W]),
      .rsp_inv_c2_r0 (rsp_flat[2*W +: W]),
      .rsp_inv_c0_r1 (rsp_flat[3*W +: W]),
      .rsp_inv_c1_r1 (rsp_flat[4*W +: W]),
      .rsp_inv_c2_r1 (rsp_flat[5*W +: W]),
      .rsp_inv_c0_r2 (rsp_flat[6*W +: W]),
      .rsp_inv_c1_r2 (rsp_flat[7*W +: W]),
      .rsp_inv_c2_r2 (rsp_flat[8*W +: W]),
      .rsp_singular  (rsp_singular)
   );

   minv_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_flat       (req_flat),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_flat       (rsp_flat),
      .rsp_singular   (rsp_singular),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .singular_count (singular_count)
   );

   // The receiver. A hold-off request from the sender parks rsp_ready low for a long
   // stretch, so the pipeline fills and req_ready drops while items keep coming.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (holds_served < holds_asked) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_LEN;
         rsp_ready    <= 1'b0;
      end else begin
         rsp_ready <= no_gaps || ($urandom_range(99) >= 12);
      end
   end

   // A stuck handshake ends the run here instead of hanging.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Offers one matrix, with a random idle gap first, and returns at the edge where
   // the transfer happens. Valid stays high straight into the next item when no gap
   // is drawn, so it is never lowered and raised in one step.
   task automatic send_matrix(input logic [9*W-1:0] m);
      while (!no_gaps && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_flat  <= m;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   function automatic logic [9*W-1:0] diag_matrix(input logic [W-1:0] d0,
                                                  input logic [W-1:0] d1,
                                                  input logic [W-1:0] d2);
      logic [9*W-1:0] m;
      m = '0;
      m[0*W +: W] = d0;
      m[4*W +: W] = d1;
      m[8*W +: W] = d2;
      return m;
   endfunction

   // One element by flavor: whole numbers give clean inverses, small raw values give
   // tiny determinants that saturate, and full-width values exercise every bit.
   function automatic logic [W-1:0] random_elem(input int flavor);
      unique case (flavor)
         0: return W'($signed($urandom_range(16)) - 8) << F;
         1: return W'($signed($urandom_range(4095)) - 2048);
         2: return W'($signed($urandom_range(32'h3ffff)) - 32'sh20000);
         default: return W'($urandom);
      endcase
   endfunction

   function automatic logic [9*W-1:0] random_matrix();
      logic [9*W-1:0] m;
      int             pick;
      int             flavor;
      pick   = $urandom_range(99);
      flavor = (pick < 40) ? 0 : (pick < 55) ? 1 : (pick < 75) ? 2 : 3;
      for (int i = 0; i < 9; i++)
         m[i * W +: W] = random_elem(($urandom_range(9) == 0) ? 3 : flavor);
      // About one in eight is made singular: a repeated row or a zero column.
      if ($urandom_range(7) == 0) begin
         if ($urandom_range(1)) begin
            m[6*W +: 3*W] = m[0 +: 3*W];
         end else begin
            for (int r = 0; r < 3; r++) m[(r * 3 + 1) * W +: W] = '0;
         end
      end
      return m;
   endfunction

   initial begin
      logic [9*W-1:0] m;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: identity, scaled diagonals, the smallest determinants in both signs
      // (saturating high and low), all-zero and repeated-row singular cases, and the
      // element extremes.
      send_matrix(diag_matrix(ONE, ONE, ONE));
      send_matrix(diag_matrix(ONE << 1, ONE << 2, -(ONE << 1)));
      send_matrix(diag_matrix(W'(1), W'(1), W'(1)));
      send_matrix(diag_matrix(-W'(1), W'(1), W'(1)));
      send_matrix(diag_matrix(EMAX, EMAX, EMAX));
      send_matrix(diag_matrix(EMIN, EMIN, EMIN));
      send_matrix(diag_matrix(EMIN, EMAX, W'(1)));
      send_matrix('0);
      send_matrix({9{EMAX}});
      send_matrix({9{EMIN}});
      m = '0;
      m[1*W +: W] = ONE;
      m[5*W +: W] = ONE;
      m[6*W +: W] = ONE;
      send_matrix(m);
      m = {ONE, ONE, ONE, -ONE, ONE << 1, ONE, ONE, W'(0), ONE << 2};
      send_matrix(m);
      m = {EMAX, EMIN, W'(1), EMIN, W'(0), EMAX, W'(1), EMAX, EMIN};
      send_matrix(m);
      send_matrix({ONE, ONE << 1, ONE, ONE << 1, ONE << 2, ONE << 1, W'(3), W'(5), W'(7)});

      for (int n = 0; n < RANDOM_CNT; n++) begin
         no_gaps = (n >= 150 && n < 300);
         if (n == 450) holds_asked++;
         if (n == 650) begin
            req_valid <= 1'b0;
            while (pending_count != 0) @(posedge clock);
         end
         send_matrix(random_matrix());
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (2 * W + 20) @(posedge clock);

      $display("Inverted %0d matrices (%0d results checked, %0d singular), including a",
               sent_count, checked_count, singular_count);
      $display("full-pipeline stall, a drain pause and saturating determinants.");
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("%0d mismatches.", fail_count);
         $display("simulation failed");
      end
      $finish;
   end
endmodule
